// File: design/vtyp_pkg.sv
// Shared constants and types for the vector_to_yaw_pitch angle pipeline.
// Holds the arctangent table, the fixed-point scaling and the side-band record.
// No dependencies.
package vtyp_pkg;

    // coordinates are scaled up by this many bits before rotation
    localparam int GUARD_BITS = 24;
    // accumulator holds degrees * 2^24; output holds degrees * 2^10
    localparam int ANGLE_SHIFT = 14;
    localparam int ACC_W       = 36;
    localparam int RND_W       = 21;
    localparam int ANGLE_W     = 20;
    localparam int OUT_TDATA_W = ((ANGLE_W + 7) / 8) * 8;
    localparam int MAX_STAGES  = 32;

    localparam logic signed [ACC_W-1:0] QUARTER_ACC = 36'sd1509949440;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS  = 36'sd8192;
    localparam logic signed [RND_W-1:0] FULL_TURN   = 21'sd368640;
    localparam logic signed [RND_W-1:0] HALF_TURN   = 21'sd184320;

    // atan(2^-i) in degrees * 2^24, rounded
    localparam logic signed [ACC_W-1:0] ATAN_TAB [MAX_STAGES] = '{
        36'sd754974720, 36'sd445687602, 36'sd235489088, 36'sd119537938,
        36'sd60000934,  36'sd30029717,  36'sd15018523,  36'sd7509720,
        36'sd3754917,   36'sd1877466,   36'sd938734,    36'sd469367,
        36'sd234684,    36'sd117342,    36'sd58671,     36'sd29335,
        36'sd14668,     36'sd7334,      36'sd3667,      36'sd1833,
        36'sd917,       36'sd458,       36'sd229,       36'sd115,
        36'sd57,        36'sd29,        36'sd14,        36'sd7,
        36'sd4,         36'sd2,         36'sd1,         36'sd0
    };

    // per-word flags that ride along the pipeline
    typedef struct packed {
        logic mode;   // 1 = pitch
        logic degen;  // x and y both zero
        logic zneg;   // z < 0
        logic zpos;   // z > 0
    } t_side;

endpackage

// File: design/vector_to_yaw_pitch.sv
// Input register, two chained unrolled vectoring CORDICs of CORDIC_STAGES registered
// micro-rotations each, a second-pass setup register and a rounding register; throughput
// one word per cycle while o_s_tready is high (it drops when the output buffer is full).
// A two-entry output buffer keeps the pipeline running while a result waits.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers keep
// whatever they hold.
module vector_to_yaw_pitch #(
    parameter int COORD_WIDTH   = 24,
    parameter int CORDIC_STAGES = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // slave side: tdata = vec_x, vec_y, vec_z from bit 0 up, zero padded to bytes
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    // tuser bit 0 = mode (0 yaw, 1 pitch)
    input  logic [0:0]                                 i_s_tuser,
    // master side: tdata = angle (bits 19:0), zero padded to bytes
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    output logic [vtyp_pkg::OUT_TDATA_W-1:0]           o_m_tdata,
    // tuser bit 0 = degenerate
    output logic [0:0]                                 o_m_tuser
);
    import vtyp_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int N     = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int DW    = COORD_WIDTH + GUARD_BITS + 4;
    localparam int LAST  = 2 * N + 2;

    // pipeline registers
    logic                    r_vld  [0:LAST];
    t_side                   r_side [0:LAST];
    logic signed [DW-1:0]    r_ax   [0:N];
    logic signed [DW-1:0]    r_ay   [0:N-1];
    logic signed [ACC_W-1:0] r_aacc [0:N];
    logic signed [DW-1:0]    r_bx   [0:N];
    logic signed [DW-1:0]    r_by   [0:N-1];
    logic signed [DW-1:0]    r_cx   [0:N-1];
    logic signed [DW-1:0]    r_cy   [0:N-1];
    logic signed [ACC_W-1:0] r_cacc [0:N];
    logic signed [RND_W-1:0] r_rnd;

    // output buffer: head word and one skid word
    logic                    r_out_vld;
    logic [ANGLE_W-1:0]      r_out_angle;
    logic                    r_out_degen;
    logic                    r_skid_vld;
    logic [ANGLE_W-1:0]      r_skid_angle;
    logic                    r_skid_degen;

    logic                    en;
    logic                    push;
    logic                    pop;

    // stage 0 next values
    logic signed [W-1:0]     x_in;
    logic signed [W-1:0]     y_in;
    logic signed [W-1:0]     z_in;
    logic signed [DW-1:0]    xs;
    logic signed [DW-1:0]    ys;
    logic signed [DW-1:0]    zs;
    logic signed [DW-1:0]    n_ax0;
    logic signed [DW-1:0]    n_ay0;
    logic signed [ACC_W-1:0] n_aacc0;
    logic signed [DW-1:0]    n_bx0;
    t_side                   n_side0;

    // final stage values
    logic signed [ACC_W-1:0] acc_b;
    logic signed [RND_W-1:0] n_rnd;
    logic signed [RND_W-1:0] wrapped;
    logic signed [RND_W-1:0] sel_angle;
    logic [ANGLE_W-1:0]      push_angle;
    logic                    push_degen;

    // advance unless the last stage holds a word with nowhere to go
    assign en         = !(r_vld[LAST] && r_skid_vld);
    assign o_s_tready = en;
    assign push       = r_vld[LAST] && en;
    assign pop        = r_out_vld && i_m_tready;

    // unpack the input word and set up the first vectoring
    always_comb begin
        x_in = $signed(i_s_tdata[W-1:0]);
        y_in = $signed(i_s_tdata[2*W-1:W]);
        z_in = $signed(i_s_tdata[3*W-1:2*W]);
        xs   = DW'(x_in) <<< GUARD_BITS;
        ys   = DW'(y_in) <<< GUARD_BITS;
        zs   = DW'(z_in) <<< GUARD_BITS;

        n_side0.mode  = i_s_tuser[0];
        n_side0.degen = (x_in == '0) && (y_in == '0);
        n_side0.zneg  = z_in[W-1];
        n_side0.zpos  = !z_in[W-1] && (z_in != '0);

        n_ax0   = xs;
        n_ay0   = ys;
        n_aacc0 = '0;
        if (i_s_tuser[0]) begin
            // pitch: magnitudes of x and y
            n_ax0 = xs[DW-1] ? -xs : xs;
            n_ay0 = ys[DW-1] ? -ys : ys;
        end else if (xs[DW-1]) begin
            // yaw, left half plane: turn by a quarter first
            if (!ys[DW-1]) begin
                n_ax0   = ys;
                n_ay0   = -xs;
                n_aacc0 = QUARTER_ACC;
            end else begin
                n_ax0   = -ys;
                n_ay0   = xs;
                n_aacc0 = -QUARTER_ACC;
            end
        end
        n_bx0 = zs[DW-1] ? -zs : zs;
    end

    // valid and side-band shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= LAST; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int j = 1; j <= LAST; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side0;
            for (int j = 1; j <= LAST; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // stage 0: load the starting vectors
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax[0]   <= n_ax0;
            r_ay[0]   <= n_ay0;
            r_aacc[0] <= n_aacc0;
            r_bx[0]   <= n_bx0;
            r_by[0]   <= '0;
        end
    end

    // first pass: vector (x,y) and (|z|,0) side by side
    for (genvar k = 0; k < N; k++) begin : g_ab
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_ay[k][DW-1]) begin
                    r_ax[k+1]   <= r_ax[k] + (r_ay[k] >>> k);
                    r_aacc[k+1] <= r_aacc[k] + ATAN_TAB[k];
                end else begin
                    r_ax[k+1]   <= r_ax[k] - (r_ay[k] >>> k);
                    r_aacc[k+1] <= r_aacc[k] - ATAN_TAB[k];
                end
                if (!r_by[k][DW-1]) begin
                    r_bx[k+1] <= r_bx[k] + (r_by[k] >>> k);
                end else begin
                    r_bx[k+1] <= r_bx[k] - (r_by[k] >>> k);
                end
            end
        end
        if (k < N - 1) begin : g_ay
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!r_ay[k][DW-1]) begin
                        r_ay[k+1] <= r_ay[k] - (r_ax[k] >>> k);
                    end else begin
                        r_ay[k+1] <= r_ay[k] + (r_ax[k] >>> k);
                    end
                    if (!r_by[k][DW-1]) begin
                        r_by[k+1] <= r_by[k] - (r_bx[k] >>> k);
                    end else begin
                        r_by[k+1] <= r_by[k] + (r_bx[k] >>> k);
                    end
                end
            end
        end
    end

    // second pass setup: pitch vector (r, -sign(z)*|z|); yaw carries its angle
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0]   <= r_ax[N];
            r_cy[0]   <= r_side[N].zpos ? -r_bx[N] : r_bx[N];
            r_cacc[0] <= r_side[N].mode ? '0 : r_aacc[N];
        end
    end

    // second pass: rotate always, accumulate only for pitch words
    for (genvar k = 0; k < N; k++) begin : g_c
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_side[N+1+k].mode) begin
                    r_cacc[k+1] <= r_cacc[k];
                end else if (!r_cy[k][DW-1]) begin
                    r_cacc[k+1] <= r_cacc[k] + ATAN_TAB[k];
                end else begin
                    r_cacc[k+1] <= r_cacc[k] - ATAN_TAB[k];
                end
            end
        end
        if (k < N - 1) begin : g_cxy
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!r_cy[k][DW-1]) begin
                        r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                        r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                    end else begin
                        r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                        r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                    end
                end
            end
        end
    end

    // round to 1/1024 degree
    always_comb begin
        acc_b = r_cacc[N] + ROUND_BIAS;
        n_rnd = $signed(acc_b[ANGLE_SHIFT+RND_W-1:ANGLE_SHIFT]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rnd <= n_rnd;
        end
    end

    // wrap yaw into one turn and substitute the degenerate answers
    always_comb begin
        if (r_rnd < 0) begin
            wrapped = r_rnd + FULL_TURN;
        end else if (r_rnd >= FULL_TURN) begin
            wrapped = r_rnd - FULL_TURN;
        end else begin
            wrapped = r_rnd;
        end
        if (r_side[LAST].degen) begin
            if (!r_side[LAST].mode) begin
                sel_angle = '0;
            end else begin
                sel_angle = r_side[LAST].zneg ? HALF_TURN : -HALF_TURN;
            end
        end else begin
            sel_angle = r_side[LAST].mode ? r_rnd : wrapped;
        end
        push_angle = sel_angle[ANGLE_W-1:0];
        push_degen = r_side[LAST].degen;
    end

    // output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (pop) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (r_out_vld) begin
                if (push && !pop) begin
                    r_skid_vld <= 1'b1;
                end else if (!push && pop) begin
                    r_out_vld <= 1'b0;
                end
            end else if (push) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    // output buffer data
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out_angle <= r_skid_angle;
                r_out_degen <= r_skid_degen;
            end
        end else if (r_out_vld) begin
            if (push && pop) begin
                r_out_angle <= push_angle;
                r_out_degen <= push_degen;
            end else if (push) begin
                r_skid_angle <= push_angle;
                r_skid_degen <= push_degen;
            end
        end else if (push) begin
            r_out_angle <= push_angle;
            r_out_degen <= push_degen;
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = OUT_TDATA_W'(r_out_angle);
    assign o_m_tuser[0] = r_out_degen;

endmodule

// File: verif/tb_vector_to_yaw_pitch.sv
// Self-checking testbench for vector_to_yaw_pitch: drives direction vectors on the
// input stream and checks every angle word against a built-in fixed-point CORDIC model.
// Depends on vtyp_pkg and the vector_to_yaw_pitch RTL.
module tb_vector_to_yaw_pitch;

    timeunit 1ns;
    timeprecision 1ps;

    import vtyp_pkg::*;

    localparam int COORD_WIDTH   = 24;
    localparam int CORDIC_STAGES = 20;
    localparam int IN_TDATA_W    = ((3*COORD_WIDTH+7)/8)*8;
    localparam int CLK_PERIOD    = 8;
    localparam int PIPE_LATENCY  = 2*CORDIC_STAGES + 3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int MAX_REPORTS   = 10;

    localparam logic MODE_YAW   = 1'b0;
    localparam logic MODE_PITCH = 1'b1;

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] C_ONE = COORD_WIDTH'(1);
    localparam logic signed [COORD_WIDTH-1:0] C_NEG = COORD_WIDTH'(-1);
    localparam logic signed [COORD_WIDTH-1:0] C_ZRO = '0;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      degen;
    } t_angle_expect;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [IN_TDATA_W-1:0]     i_s_tdata  = '0;
    logic [0:0]                i_s_tuser  = '0;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    o_m_tdata;
    logic [0:0]                o_m_tuser;

    t_angle_expect angle_expect_q[$];
    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    logic hold_off_req = 1'b0;
    int  hold_off_left = 0;
    int  mismatches    = 0;
    int  words_checked = 0;
    int  n_yaw         = 0;
    int  n_pitch       = 0;
    int  n_degen       = 0;
    int  cycle_count   = 0;
    int  max_hold_backlog = 0;

    vector_to_yaw_pitch #(
        .COORD_WIDTH   (COORD_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // vec_x, vec_y, vec_z from bit 0 up
        .i_s_tuser  (i_s_tuser),   // mode
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // angle, zero padded
        .o_m_tuser  (o_m_tuser)    // degenerate
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // Vectoring CORDIC: rotate y toward zero, return summed angle and final x.
    function automatic longint cordic_vectoring(input longint x_in, input longint y_in,
                                                output longint x_out);
        longint x, y, xs, ys, acc;
        int     n;
        x   = x_in;
        y   = y_in;
        acc = 0;
        n   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + longint'(ATAN_TAB[i]);
            end else begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - longint'(ATAN_TAB[i]);
            end
        end
        x_out = x;
        return acc;
    endfunction

    // Expected angle word for one vector.
    function automatic t_angle_expect predict_angle(input logic mode,
                                                    input logic signed [COORD_WIDTH-1:0] vx,
                                                    input logic signed [COORD_WIDTH-1:0] vy,
                                                    input logic signed [COORD_WIDTH-1:0] vz);
        longint x, y, z, xs, ys, swap, base, ax, ay, az, mag_r, mag_z, unused, ang;
        t_angle_expect res;
        x = longint'(vx);
        y = longint'(vy);
        z = longint'(vz);
        res.degen = 1'b0;
        if (x == 0 && y == 0) begin
            res.degen = 1'b1;
            if (mode == MODE_YAW)
                ang = 0;
            else
                ang = (z < 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
        end else if (mode == MODE_YAW) begin
            xs   = x <<< GUARD_BITS;
            ys   = y <<< GUARD_BITS;
            base = 0;
            // left half-plane: pre-rotate by a quarter turn
            if (xs < 0) begin
                swap = xs;
                if (ys >= 0) begin
                    xs   = ys;
                    ys   = -swap;
                    base = longint'(QUARTER_ACC);
                end else begin
                    xs   = -ys;
                    ys   = swap;
                    base = -longint'(QUARTER_ACC);
                end
            end
            ang = (base + cordic_vectoring(xs, ys, unused) + longint'(ROUND_BIAS))
                  >>> ANGLE_SHIFT;
            if (ang < 0)
                ang = ang + longint'(FULL_TURN);
            if (ang >= longint'(FULL_TURN))
                ang = ang - longint'(FULL_TURN);
        end else begin
            ax = ((x < 0) ? -x : x) <<< GUARD_BITS;
            ay = ((y < 0) ? -y : y) <<< GUARD_BITS;
            az = ((z < 0) ? -z : z) <<< GUARD_BITS;
            void'(cordic_vectoring(ax, ay, mag_r));
            void'(cordic_vectoring(az, 0, mag_z));
            ang = (cordic_vectoring(mag_r, (z > 0) ? -mag_z : mag_z, unused)
                   + longint'(ROUND_BIAS)) >>> ANGLE_SHIFT;
        end
        res.angle = ang[ANGLE_W-1:0];
        return res;
    endfunction

    // Offer one vector, wait for acceptance, then queue its expected angle.
    task automatic send_vector(input logic mode,
                               input logic signed [COORD_WIDTH-1:0] vx,
                               input logic signed [COORD_WIDTH-1:0] vy,
                               input logic signed [COORD_WIDTH-1:0] vz);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {vz, vy, vx};
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        angle_expect_q.push_back(predict_angle(mode, vx, vy, vz));
        if (mode == MODE_YAW)
            n_yaw++;
        else
            n_pitch++;
        if (vx == 0 && vy == 0)
            n_degen++;
    endtask

    // Mix of full-range, tiny and extreme coordinates.
    function automatic logic signed [COORD_WIDTH-1:0] random_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return COORD_WIDTH'($urandom());
        if (pick < 8)
            return COORD_WIDTH'(int'($urandom_range(0, 32)) - 16);
        case ($urandom_range(0, 4))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return C_NEG;
            3:       return C_ONE;
            default: return C_ZRO;
        endcase
    endfunction

    task automatic send_random_vector();
        logic signed [COORD_WIDTH-1:0] vx, vy, vz;
        int kind;
        kind = $urandom_range(0, 9);
        vx = random_coord();
        vy = random_coord();
        vz = random_coord();
        // occasionally force the degenerate case or a vector on an axis
        if (kind == 0) begin
            vx = '0;
            vy = '0;
        end else if (kind == 1) begin
            if ($urandom_range(0, 1))
                vx = '0;
            else
                vy = '0;
        end
        send_vector(1'($urandom_range(0, 1)), vx, vy, vz);
    endtask

    task automatic test_corner_vectors();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        // degenerate vectors in both modes, z on each side of zero
        send_vector(MODE_YAW,   C_ZRO, C_ZRO, C_ZRO);
        send_vector(MODE_YAW,   C_ZRO, C_ZRO, C_MIN);
        send_vector(MODE_PITCH, C_ZRO, C_ZRO, C_NEG);
        send_vector(MODE_PITCH, C_ZRO, C_ZRO, C_ZRO);
        send_vector(MODE_PITCH, C_ZRO, C_ZRO, C_MAX);
        // yaw on the axes and in the second, third and fourth quadrants, both pre-rotation branches
        send_vector(MODE_YAW,   C_MAX, C_ZRO, C_ZRO);
        send_vector(MODE_YAW,   C_ZRO, C_MAX, C_ZRO);
        send_vector(MODE_YAW,   C_MIN, C_ZRO, C_ZRO);
        send_vector(MODE_YAW,   C_ZRO, C_MIN, C_ZRO);
        send_vector(MODE_YAW,   C_MIN, C_MIN, C_MAX);
        send_vector(MODE_YAW,   C_MIN, C_MAX, C_MIN);
        send_vector(MODE_YAW,   C_MAX, C_MIN, C_ZRO);
        // yaw just below zero wraps to near a full turn
        send_vector(MODE_YAW,   C_MAX, C_NEG, C_ZRO);
        send_vector(MODE_YAW,   C_MAX, C_ONE, C_ZRO);
        send_vector(MODE_YAW,   C_NEG, C_NEG, C_ZRO);
        send_vector(MODE_YAW,   C_ONE, C_ONE, C_ZRO);
        send_vector(MODE_YAW,   C_NEG, C_ZRO, C_ZRO);
        // pitch extremes, straight up and down, level
        send_vector(MODE_PITCH, C_MAX, C_MAX, C_MIN);
        send_vector(MODE_PITCH, C_MIN, C_MIN, C_MAX);
        send_vector(MODE_PITCH, C_ONE, C_ZRO, C_MAX);
        send_vector(MODE_PITCH, C_ONE, C_ZRO, C_MIN);
        send_vector(MODE_PITCH, C_MAX, C_ZRO, C_ZRO);
        send_vector(MODE_PITCH, C_NEG, C_ONE, C_ONE);
        send_vector(MODE_PITCH, C_MIN, C_MAX, C_MIN);
    endtask

    task automatic test_random_vectors(input int idle_pct, input int stall_pct,
                                       input int count);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (count)
            send_random_vector();
    endtask

    // Hold the output off for a long stretch while words keep coming in.
    task automatic test_output_hold_off(input int count);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_off_req <= 1'b1;
        repeat (count)
            send_random_vector();
    endtask

    // Output ready: long hold-off on request, random stalls otherwise.
    always @(posedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req  <= 1'b0;
            hold_off_left  = HOLD_OFF_LEN;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_m_tready <= 1'b0;
            if (angle_expect_q.size() > max_hold_backlog)
                max_hold_backlog = angle_expect_q.size();
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Compare each accepted angle word with the oldest expectation.
    always @(posedge i_clk) begin
        t_angle_expect want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (angle_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: angle %0d degen %0b",
                             $signed(o_m_tdata[ANGLE_W-1:0]), o_m_tuser[0]);
            end else begin
                want = angle_expect_q.pop_front();
                words_checked++;
                if (o_m_tdata[ANGLE_W-1:0] !== want.angle || o_m_tuser[0] !== want.degen) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word %0d mismatch: expected angle %0d degen %0b, got %0d %0b",
                                 words_checked, want.angle, want.degen,
                                 $signed(o_m_tdata[ANGLE_W-1:0]), o_m_tuser[0]);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, angle_expect_q.size());
            $display("tb_vector_to_yaw_pitch failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_vectors();
        test_random_vectors(0, 0, 440);
        test_output_hold_off(150);
        test_random_vectors(58, 0, 440);
        test_random_vectors(0, 58, 440);
        test_random_vectors(21, 21, 440);

        // drain
        i_s_tvalid    <= 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        while (angle_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        mismatches = mismatches + angle_expect_q.size();
        $display("covered %0d yaw and %0d pitch vectors (%0d with x=y=0), %0d words checked",
                 n_yaw, n_pitch, n_degen, words_checked);
        $display("peak backlog during output hold-off: %0d words, %0d mismatches, %0d cycles",
                 max_hold_backlog, mismatches, cycle_count);
        if (mismatches == 0)
            $display("tb_vector_to_yaw_pitch passed");
        else
            $display("tb_vector_to_yaw_pitch failed");
        $finish;
    end

endmodule
